[sv/tfpe_pkg.sv]
// ----------------------------------------------------------------------------
// tfpe_pkg
// shared types, widths and constants of the three fiducial pose estimator
// ----------------------------------------------------------------------------
`default_nettype none

package tfpe_pkg;

  localparam int FW           = 16;
  localparam int COORD_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int CW   = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam int DW   = CW + 1;
  localparam int SQIN = 2 * CW + 10;
  localparam int RTW  = SQIN / 2;
  localparam int RMW  = RTW + 2;
  localparam int PW   = RTW + 2;
  localparam int DENW = PW + 7;
  localparam int RW   = 13;
  localparam int NW   = (((CW + 3) > 19) ? (CW + 3) : 19) + 1;
  localparam int MPW  = 28;
  localparam int MAGW = NW - 1 + MPW;
  localparam int NUMW = MAGW + 1;
  localparam int VW   = NUMW + 2;

  localparam int ANGLE_LEN = 24;
  localparam int NST       = (CORDIC_STEPS < ANGLE_LEN) ? CORDIC_STEPS : ANGLE_LEN;
  localparam int XW        = CW + 11;
  localparam int ZW        = 32;
  localparam int TZW       = ZW - 15;

  localparam int BACK_LAT = RTW + NUMW + 4;
  localparam int ITEM_LAT = BACK_LAT + 2;
  localparam int ROT_DLY  = RTW + NUMW + 2 - NST;

  localparam logic [MPW-1:0]        MODEL_PERIM_Q32 = 28'd169542133;
  localparam logic signed [VW-1:0]  MODEL_CX_Q24    = VW'(280);
  localparam logic signed [VW-1:0]  MODEL_CY_Q24    = VW'(28298);
  localparam logic signed [TZW-1:0] ROT_LIMIT       = TZW'(25736);
  localparam logic signed [VW-1:0]  OFS_MAX         = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0]  OFS_MIN         = -VW'(64'sd2147483648);

  localparam logic [RW-1:0] ROWS_RESET = RW'(480);
  localparam logic [RW-1:0] COLS_RESET = RW'(640);

  localparam int IDXW = 1;
  localparam logic [IDXW-1:0] REG_ROWS = 1'b0;
  localparam logic [IDXW-1:0] REG_COLS = 1'b1;

  typedef struct packed {
    logic [FW-1:0] point_a_x;
    logic [FW-1:0] point_a_y;
    logic [FW-1:0] point_b_x;
    logic [FW-1:0] point_b_y;
    logic [FW-1:0] point_c_x;
    logic [FW-1:0] point_c_y;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [15:0] rotation;
    logic               status;
  } res_t;

  typedef struct packed {
    logic signed [DW-1:0] s0x;
    logic signed [DW-1:0] s0y;
    logic signed [DW-1:0] s1x;
    logic signed [DW-1:0] s1y;
    logic signed [DW-1:0] s2x;
    logic signed [DW-1:0] s2y;
    logic signed [DW-1:0] bdx;
    logic signed [DW-1:0] bdy;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [ZW-1:0] atan_q30(input int unsigned i);
    logic [ZW-1:0] a;
    case (i)
      0:  a = 32'd843314856;
      1:  a = 32'd497837829;
      2:  a = 32'd263043836;
      3:  a = 32'd133525158;
      4:  a = 32'd67021686;
      5:  a = 32'd33543515;
      6:  a = 32'd16775850;
      7:  a = 32'd8388437;
      8:  a = 32'd4194282;
      9:  a = 32'd2097149;
      10: a = 32'd1048575;
      11: a = 32'd524287;
      12: a = 32'd262143;
      13: a = 32'd131071;
      14: a = 32'd65535;
      15: a = 32'd32767;
      16: a = 32'd16383;
      17: a = 32'd8191;
      18: a = 32'd4095;
      19: a = 32'd2047;
      20: a = 32'd1023;
      21: a = 32'd511;
      22: a = 32'd255;
      23: a = 32'd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[sv/tfpe_front.sv]
// ----------------------------------------------------------------------------
// tfpe_front
// accepts point triples, picks head and base, forms differences and sums
// ----------------------------------------------------------------------------
`default_nettype none

module tfpe_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire tfpe_pkg::cmd_t            cmd,
  input  wire logic                      cfg_we,
  input  wire logic [tfpe_pkg::IDXW-1:0] cfg_idx,
  input  wire logic [tfpe_pkg::RW-1:0]   cfg_data,
  input  wire tfpe_pkg::qstat_t          qs,
  output logic                           push,
  output tfpe_pkg::qitem_t               item
);

  localparam int CW = tfpe_pkg::CW;
  localparam int DW = tfpe_pkg::DW;
  localparam int NW = tfpe_pkg::NW;

  logic [tfpe_pkg::RW-1:0] rows;
  logic [tfpe_pkg::RW-1:0] cols;
  logic                    f_valid;
  logic                    f_valid_next;
  logic                    accept;
  tfpe_pkg::qitem_t        item_next;

  logic [CW-1:0] x0, y0, x1, y1, x2, y2;
  logic [CW-1:0] hx0, hy0, hx1, hy1;
  logic [1:0]    head;
  logic [CW+1:0] sx, sy;
  logic [NW-1:0] colsw, rowsw;

  assign busy   = f_valid && qs.full;
  assign accept = start && !busy;
  assign push   = f_valid && !qs.full;

  always_comb begin
    x0 = cmd.point_a_x[CW-1:0];
    y0 = cmd.point_a_y[CW-1:0];
    x1 = cmd.point_b_x[CW-1:0];
    y1 = cmd.point_b_y[CW-1:0];
    x2 = cmd.point_c_x[CW-1:0];
    y2 = cmd.point_c_y[CW-1:0];
    head = 2'd0;
    if (y1 < y0) begin
      head = 2'd1;
    end
    if ((head == 2'd0 && y2 < y0) || (head == 2'd1 && y2 < y1)) begin
      head = 2'd2;
    end
    hx0 = x0;
    hy0 = y0;
    hx1 = x1;
    hy1 = y1;
    if (head == 2'd0) begin
      hx0 = x1;
      hy0 = y1;
      hx1 = x2;
      hy1 = y2;
    end else if (head == 2'd1) begin
      hx1 = x2;
      hy1 = y2;
    end
    sx    = {2'b00, x0} + {2'b00, x1} + {2'b00, x2};
    sy    = {2'b00, y0} + {2'b00, y1} + {2'b00, y2};
    colsw = NW'(cols);
    rowsw = NW'(rows);
    item_next.s0x = $signed({1'b0, x1}) - $signed({1'b0, x0});
    item_next.s0y = $signed({1'b0, y1}) - $signed({1'b0, y0});
    item_next.s1x = $signed({1'b0, x2}) - $signed({1'b0, x1});
    item_next.s1y = $signed({1'b0, y2}) - $signed({1'b0, y1});
    item_next.s2x = $signed({1'b0, x0}) - $signed({1'b0, x2});
    item_next.s2y = $signed({1'b0, y0}) - $signed({1'b0, y2});
    item_next.bdx = $signed({1'b0, hx1}) - $signed({1'b0, hx0});
    item_next.bdy = $signed({1'b0, hy1}) - $signed({1'b0, hy0});
    item_next.nx  = $signed((NW'(sx) << 1) - (colsw << 5) - (colsw << 4));
    item_next.ny  = $signed((NW'(sy) << 1) - (rowsw << 5) - (rowsw << 4));
  end

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows    <= tfpe_pkg::ROWS_RESET;
      cols    <= tfpe_pkg::COLS_RESET;
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
      if (cfg_we) begin
        case (cfg_idx)
          tfpe_pkg::REG_ROWS: rows <= cfg_data;
          tfpe_pkg::REG_COLS: cols <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[sv/tfpe_queue.sv]
// ----------------------------------------------------------------------------
// tfpe_queue
// two entry queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module tfpe_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tfpe_pkg::qitem_t din,
  input  wire logic             pop,
  output tfpe_pkg::qitem_t      dout,
  output tfpe_pkg::qstat_t      qs
);

  tfpe_pkg::qitem_t mem [0:1];
  logic             wr;
  logic             rd;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign qs.full  = (cnt == 2'd2);
  assign qs.empty = (cnt == 2'd0);
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;
  assign dout     = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr <= !wr;
      end
      if (do_pop) begin
        rd <= !rd;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr] <= din;
    end
  end

endmodule

`default_nettype wire

[sv/tfpe_sqrt.sv]
// ----------------------------------------------------------------------------
// tfpe_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module tfpe_sqrt (
  input  wire logic                      clk,
  input  wire logic [tfpe_pkg::SQIN-1:0] rad,
  output logic [tfpe_pkg::RTW-1:0]       root
);

  localparam int SQIN = tfpe_pkg::SQIN;
  localparam int RTW  = tfpe_pkg::RTW;
  localparam int RMW  = tfpe_pkg::RMW;

  logic [SQIN-1:0] sr [1:RTW-1];
  logic [RMW-1:0]  rm [1:RTW-1];
  logic [RTW-1:0]  ro [1:RTW];

  for (genvar s = 0; s < RTW; s++) begin : g_stage
    logic [SQIN-1:0] pr;
    logic [RMW-1:0]  pm;
    logic [RTW-1:0]  po;
    logic [RMW+1:0]  t;
    logic [RMW+1:0]  tr;
    logic            ge;
    if (s == 0) begin : g_first
      assign pr = rad;
      assign pm = '0;
      assign po = '0;
    end else begin : g_mid
      assign pr = sr[s];
      assign pm = rm[s];
      assign po = ro[s];
    end
    assign t  = {pm, pr[SQIN-1:SQIN-2]};
    assign tr = (RMW + 2)'({po, 2'b01});
    assign ge = (t >= tr);
    always_ff @(posedge clk) begin
      ro[s+1] <= {po[RTW-2:0], ge};
    end
    if (s < RTW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        sr[s+1] <= pr << 2;
        rm[s+1] <= ge ? RMW'(t - tr) : RMW'(t);
      end
    end
  end

  assign root = ro[RTW];

endmodule

`default_nettype wire

[sv/tfpe_back.sv]
// ----------------------------------------------------------------------------
// tfpe_back
// side lengths, perimeter divide, cordic angle and result assembly
// ----------------------------------------------------------------------------
`default_nettype none

module tfpe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop,
  input  wire tfpe_pkg::qitem_t item,
  output logic                  done,
  output tfpe_pkg::res_t        result
);

  localparam int CW   = tfpe_pkg::CW;
  localparam int DW   = tfpe_pkg::DW;
  localparam int SQIN = tfpe_pkg::SQIN;
  localparam int RTW  = tfpe_pkg::RTW;
  localparam int PW   = tfpe_pkg::PW;
  localparam int DENW = tfpe_pkg::DENW;
  localparam int NW   = tfpe_pkg::NW;
  localparam int MAGW = tfpe_pkg::MAGW;
  localparam int NUMW = tfpe_pkg::NUMW;
  localparam int VW   = tfpe_pkg::VW;
  localparam int NST  = tfpe_pkg::NST;
  localparam int XW   = tfpe_pkg::XW;
  localparam int ZW   = tfpe_pkg::ZW;
  localparam int TZW  = tfpe_pkg::TZW;
  localparam int VL   = tfpe_pkg::BACK_LAT;
  localparam int RDL  = tfpe_pkg::ROT_DLY;

  typedef struct packed {
    logic negx;
    logic negy;
    logic stat;
  } side_t;

  function automatic logic [2*CW:0] dsq(input logic signed [DW-1:0] a,
                                        input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] pa;
    logic signed [2*DW-1:0] pb;
    pa = a * a;
    pb = b * b;
    return {1'b0, pa[2*CW-1:0]} + {1'b0, pb[2*CW-1:0]};
  endfunction

  function automatic logic signed [VW-1:0] fin(input logic [NUMW-1:0] q,
                                               input logic neg,
                                               input logic signed [VW-1:0] c);
    logic signed [VW-1:0] v;
    v = $signed({2'b00, q});
    if (neg) begin
      v = -v;
    end
    v = v - c;
    if (v > tfpe_pkg::OFS_MAX) begin
      v = tfpe_pkg::OFS_MAX;
    end else if (v < tfpe_pkg::OFS_MIN) begin
      v = tfpe_pkg::OFS_MIN;
    end
    return v;
  endfunction

  logic                   vl [0:VL-1];
  logic [SQIN-1:0]        sq_r [0:2];
  logic [RTW-1:0]         rt [0:2];
  logic signed [NW-1:0]   nxd [0:RTW];
  logic signed [NW-1:0]   nyd [0:RTW];

  logic [PW-1:0]          perim_r;
  logic [MAGW-1:0]        magx_r;
  logic [MAGW-1:0]        magy_r;
  logic                   negx_r;
  logic                   negy_r;
  logic [NW-2:0]          anx;
  logic [NW-2:0]          any_n;
  logic [DENW-1:0]        den;

  logic [NUMW-1:0]        dnx [0:NUMW-1];
  logic [NUMW-1:0]        dny [0:NUMW-1];
  logic [DENW-1:0]        drx [0:NUMW-1];
  logic [DENW-1:0]        dry [0:NUMW-1];
  logic [NUMW-1:0]        dqx [0:NUMW];
  logic [NUMW-1:0]        dqy [0:NUMW];
  logic [DENW-1:0]        dden [0:NUMW-1];
  side_t                  dside [0:NUMW];

  logic signed [XW-1:0]   cx [0:NST-1];
  logic signed [XW-1:0]   cy [0:NST-1];
  logic signed [ZW-1:0]   cz [0:NST];
  logic                   czf [0:NST];
  logic signed [ZW:0]     zr;
  logic signed [TZW-1:0]  tq;
  logic signed [TZW-1:0]  rr;
  logic signed [15:0]     rd [0:RDL-1];
  logic signed [DW-1:0]   adx;
  logic signed [DW-1:0]   sdy;

  tfpe_pkg::res_t         res_next;

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VL; k++) begin
        vl[k] <= 1'b0;
      end
    end else begin
      vl[0] <= pop;
      for (int k = 1; k < VL; k++) begin
        vl[k] <= vl[k-1];
      end
    end
  end

  // squared side lengths
  always_ff @(posedge clk) begin
    sq_r[0] <= {1'b0, dsq(item.s0x, item.s0y), 8'd0};
    sq_r[1] <= {1'b0, dsq(item.s1x, item.s1y), 8'd0};
    sq_r[2] <= {1'b0, dsq(item.s2x, item.s2y), 8'd0};
    nxd[0]  <= item.nx;
    nyd[0]  <= item.ny;
    for (int k = 1; k <= RTW; k++) begin
      nxd[k] <= nxd[k-1];
      nyd[k] <= nyd[k-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_side
    tfpe_sqrt u_sqrt (
      .clk  (clk),
      .rad  (sq_r[k]),
      .root (rt[k])
    );
  end

  // perimeter and scaled centroid offsets
  assign anx   = (NW - 1)'(nxd[RTW] < 0 ? -nxd[RTW] : nxd[RTW]);
  assign any_n = (NW - 1)'(nyd[RTW] < 0 ? -nyd[RTW] : nyd[RTW]);
  assign den   = (DENW'(perim_r) << 6) + (DENW'(perim_r) << 5);

  always_ff @(posedge clk) begin
    perim_r <= PW'(rt[0]) + PW'(rt[1]) + PW'(rt[2]);
    magx_r  <= MAGW'(anx * tfpe_pkg::MODEL_PERIM_Q32);
    magy_r  <= MAGW'(any_n * tfpe_pkg::MODEL_PERIM_Q32);
    negx_r  <= nxd[RTW] < 0;
    negy_r  <= nyd[RTW] < 0;
    dnx[0]  <= {1'b0, magx_r} + NUMW'(den >> 1);
    dny[0]  <= {1'b0, magy_r} + NUMW'(den >> 1);
    drx[0]  <= '0;
    dry[0]  <= '0;
    dqx[0]  <= '0;
    dqy[0]  <= '0;
    dden[0] <= den;
    dside[0] <= '{negx: negx_r, negy: negy_r, stat: (perim_r == '0)};
  end

  // restoring divide, one quotient bit per stage
  for (genvar s = 1; s <= NUMW; s++) begin : g_div
    logic [DENW:0] tx;
    logic [DENW:0] ty;
    logic          gx;
    logic          gy;
    assign tx = {drx[s-1], dnx[s-1][NUMW-1]};
    assign ty = {dry[s-1], dny[s-1][NUMW-1]};
    assign gx = (tx >= {1'b0, dden[s-1]});
    assign gy = (ty >= {1'b0, dden[s-1]});
    always_ff @(posedge clk) begin
      dqx[s]   <= {dqx[s-1][NUMW-2:0], gx};
      dqy[s]   <= {dqy[s-1][NUMW-2:0], gy};
      dside[s] <= dside[s-1];
    end
    if (s < NUMW) begin : g_carry
      always_ff @(posedge clk) begin
        dnx[s]  <= dnx[s-1] << 1;
        dny[s]  <= dny[s-1] << 1;
        drx[s]  <= gx ? DENW'(tx - {1'b0, dden[s-1]}) : DENW'(tx);
        dry[s]  <= gy ? DENW'(ty - {1'b0, dden[s-1]}) : DENW'(ty);
        dden[s] <= dden[s-1];
      end
    end
  end

  // cordic vectoring on the base line
  assign adx = (item.bdx < 0) ? -item.bdx : item.bdx;
  assign sdy = (item.bdx < 0) ? -item.bdy : item.bdy;

  always_ff @(posedge clk) begin
    cx[0]  <= XW'(adx) <<< 8;
    cy[0]  <= XW'(sdy) <<< 8;
    cz[0]  <= '0;
    czf[0] <= (item.bdx == '0);
  end

  for (genvar s = 1; s <= NST; s++) begin : g_cordic
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;
    assign xs = cx[s-1] >>> (s - 1);
    assign ys = cy[s-1] >>> (s - 1);
    assign at = $signed(tfpe_pkg::atan_q30(s - 1));
    always_ff @(posedge clk) begin
      cz[s]  <= (cy[s-1] >= 0) ? cz[s-1] + at : cz[s-1] - at;
      czf[s] <= czf[s-1];
    end
    if (s < NST) begin : g_carry
      always_ff @(posedge clk) begin
        cx[s] <= (cy[s-1] >= 0) ? cx[s-1] + ys : cx[s-1] - ys;
        cy[s] <= (cy[s-1] >= 0) ? cy[s-1] - xs : cy[s-1] + xs;
      end
    end
  end

  always_comb begin
    zr = {cz[NST][ZW-1], cz[NST]} + (ZW + 1)'(1 << 15);
    tq = $signed(zr[ZW:16]);
    rr = -tq;
    if (czf[NST] || rr > tfpe_pkg::ROT_LIMIT) begin
      rr = tfpe_pkg::ROT_LIMIT;
    end else if (rr < -tfpe_pkg::ROT_LIMIT) begin
      rr = -tfpe_pkg::ROT_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    rd[0] <= rr[15:0];
    for (int k = 1; k < RDL; k++) begin
      rd[k] <= rd[k-1];
    end
  end

  // result assembly
  always_comb begin
    res_next.rotation = rd[RDL-1];
    res_next.status   = dside[NUMW].stat;
    res_next.offset_x = '0;
    res_next.offset_y = '0;
    if (!dside[NUMW].stat) begin
      res_next.offset_x = 32'(fin(dqx[NUMW], dside[NUMW].negx, tfpe_pkg::MODEL_CX_Q24));
      res_next.offset_y = 32'(fin(dqy[NUMW], dside[NUMW].negy, tfpe_pkg::MODEL_CY_Q24));
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  assign done = vl[VL-1];

endmodule

`default_nettype wire

[sv/three_fiducial_pose_estimate.sv]
// ----------------------------------------------------------------------------
// three_fiducial_pose_estimate
// board pose from three fiducial centres: rotation and translation
// ----------------------------------------------------------------------------
// usage
//   input: drive cmd with the three points and raise start; an item is
//   taken at each rising edge with start high and busy low
//   config: cfg_we with cfg_idx 0 (image rows) or 1 (image cols) writes
//   cfg_data; write only while no item is in flight
//   output: done is high for one cycle with result holding offsets,
//   rotation and status; there is no back pressure on the result side
//   structure: the 48 stage divider sits behind the 21 stage square root;
//   sqrt, divider and cordic are fully pipelined, so one item is accepted
//   every cycle while busy is low
//   busy only rises if the front queue fills, which the back never allows
//   reset: rst synchronously empties the pipeline and sets rows 480 and
//   cols 640
// ----------------------------------------------------------------------------
`default_nettype none

module three_fiducial_pose_estimate (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire tfpe_pkg::cmd_t            cmd,
  input  wire logic                      cfg_we,
  input  wire logic [tfpe_pkg::IDXW-1:0] cfg_idx,
  input  wire logic [tfpe_pkg::RW-1:0]   cfg_data,
  output logic                           done,
  output tfpe_pkg::res_t                 result
);

  tfpe_pkg::qitem_t f_item;
  tfpe_pkg::qitem_t q_item;
  tfpe_pkg::qstat_t qs;
  logic             push;
  logic             pop;

  assign pop = !qs.empty;

  tfpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .qs       (qs),
    .push     (push),
    .item     (f_item)
  );

  tfpe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (f_item),
    .pop  (pop),
    .dout (q_item),
    .qs   (qs)
  );

  tfpe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pop    (pop),
    .item   (q_item),
    .done   (done),
    .result (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(tfpe_pkg::ITEM_LAT) done)
    else $error("item result missing at fixed latency");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !qs.full)
    else $error("front queue filled");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.offset_x == 0 && result.offset_y == 0))
    else $error("zero perimeter result with nonzero offset");

endmodule

`default_nettype wire
